// ----- src/cpa_pkg.sv -----
// Package for the contiguous page allocator: shared constants, codes and types.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package cpa_pkg;

  // Default geometry of the page table
  localparam int NUM_PAGES_DEF  = 256;
  localparam int PAGE_BYTES_DEF = 4096;

  // Field widths of the words on the channels
  localparam int COUNT_W = 9;
  localparam int OWNER_W = 16;
  localparam int ADDR_W  = 32;
  localparam int RAM_W   = 29;

  // Cap on the end of the bump region (508 MiB)
  localparam logic [ADDR_W-1:0] RAM_CAP = ADDR_W'(508 * 1024 * 1024);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TABLE_MODE = 2'd0,
    REG_BUMP_START = 2'd1,
    REG_RAM_SIZE   = 2'd2,
    REG_TABLE_BASE = 2'd3
  } cpa_reg_t;

  // Request types
  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_REGION = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_ADD,
    ST_MARK,
    ST_DONE
  } cpa_state_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_fire;
    logic region;
    logic skip;
    logic table_mode;
    logic mark_last;
    logic out_free;
  } cpa_stat_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic decide;
    logic mul_en;
    logic add_en;
    logic mark_en;
    logic emit;
  } cpa_ctrl_t;

endpackage

// ----- src/cpa_if.sv -----
// Valid/ready channel interfaces for the allocator's request and response words.
// Depends on cpa_pkg for field widths.
`timescale 1ns / 1ps

interface cpa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [cpa_pkg::COUNT_W-1:0]  page_count;
  logic [cpa_pkg::OWNER_W-1:0]  owner_id;

  modport source (output valid, req_type, page_count, owner_id, input ready);
  modport sink   (input valid, req_type, page_count, owner_id, output ready);
endinterface

interface cpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cpa_pkg::ADDR_W-1:0]   phys_addr;
  logic [cpa_pkg::ADDR_W-1:0]   region_lo;
  logic [cpa_pkg::ADDR_W-1:0]   region_hi;

  modport source (output valid, phys_addr, region_lo, region_hi, input ready);
  modport sink   (input valid, phys_addr, region_lo, region_hi, output ready);
endinterface

// ----- src/cpa_alu.sv -----
// Shared arithmetic unit: page-size multiply, 33-bit add and overflow compare.
// Depends on cpa_pkg; results are registered by the caller.
`timescale 1ns / 1ps

module cpa_alu #(
  parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
  input  logic [cpa_pkg::ADDR_W-1:0] mul_a,
  input  logic [cpa_pkg::ADDR_W-1:0] add_a,
  input  logic [cpa_pkg::ADDR_W-1:0] add_b,
  input  logic [cpa_pkg::ADDR_W-1:0] lim,
  output logic [cpa_pkg::ADDR_W-1:0] prod,
  output logic [cpa_pkg::ADDR_W:0]   sum,
  output logic                       over
);

  localparam logic [cpa_pkg::ADDR_W-1:0] PB = cpa_pkg::ADDR_W'(PAGE_BYTES);

  // scale by page size, modulo 2^32
  assign prod = mul_a * PB;

  // add without wrap, then check against the limit
  assign sum  = {1'b0, add_a} + {1'b0, add_b};
  assign over = sum > {1'b0, lim};

endmodule

// ----- src/cpa_page_mem.sv -----
// Per-page owner tags and run lengths, written one entry per cycle while marking.
// Depends on cpa_pkg for field widths.
`timescale 1ns / 1ps

module cpa_page_mem #(
  parameter int NUM_PAGES = cpa_pkg::NUM_PAGES_DEF,
  parameter int IW        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         head,
  input  logic [IW-1:0]                addr,
  input  logic [cpa_pkg::OWNER_W-1:0]  owner,
  input  logic [cpa_pkg::COUNT_W-1:0]  run_len
);

  logic [cpa_pkg::OWNER_W-1:0] owner_mem  [NUM_PAGES];
  logic [cpa_pkg::COUNT_W-1:0] runlen_mem [NUM_PAGES];

  // tag every page of the run; the run length goes to its first page only
  always_ff @(posedge clk) begin
    if (we) begin
      owner_mem[addr] <= owner;
      if (head) begin
        runlen_mem[addr] <= run_len;
      end
    end
  end

endmodule

// ----- src/cpa_seq.sv -----
// Sequencer of the allocator: walks one request through decide, multiply,
// add and mark steps on the shared unit. Depends on cpa_pkg.
`timescale 1ns / 1ps

module cpa_seq (
  input  logic               clk,
  input  logic               rst,
  input  cpa_pkg::cpa_stat_t stat,
  output cpa_pkg::cpa_ctrl_t ctrl
);

  cpa_pkg::cpa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cpa_pkg::ST_IDLE: begin
        if (stat.in_fire) state_next = cpa_pkg::ST_DECIDE;
      end
      cpa_pkg::ST_DECIDE: begin
        if (stat.region || stat.skip) state_next = cpa_pkg::ST_DONE;
        else                          state_next = cpa_pkg::ST_MUL;
      end
      cpa_pkg::ST_MUL: begin
        state_next = cpa_pkg::ST_ADD;
      end
      cpa_pkg::ST_ADD: begin
        state_next = stat.table_mode ? cpa_pkg::ST_MARK : cpa_pkg::ST_DONE;
      end
      cpa_pkg::ST_MARK: begin
        if (stat.mark_last) state_next = cpa_pkg::ST_DONE;
      end
      cpa_pkg::ST_DONE: begin
        if (stat.out_free) state_next = cpa_pkg::ST_IDLE;
      end
      default: state_next = cpa_pkg::ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    ctrl          = '0;
    ctrl.in_ready = (state == cpa_pkg::ST_IDLE);
    ctrl.decide   = (state == cpa_pkg::ST_DECIDE);
    ctrl.mul_en   = (state == cpa_pkg::ST_MUL);
    ctrl.add_en   = (state == cpa_pkg::ST_ADD);
    ctrl.mark_en  = (state == cpa_pkg::ST_MARK);
    ctrl.emit     = (state == cpa_pkg::ST_DONE) && stat.out_free;
  end

endmodule

// ----- src/contiguous_page_allocator_core.sv -----
// Top level of the contiguous page allocator: config registers, bump and
// fill-count state, datapath around cpa_alu, cpa_seq and cpa_page_mem.
// Depends on cpa_pkg and the cpa_req_if / cpa_rsp_if interfaces.
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+-----------------------------------------
//  req     | in  | valid/ready     | req_type, page_count, owner_id
//  rsp     | out | valid/ready     | phys_addr, region_lo, region_hi
//  wr      | in  | wr_en only      | wr_index, wr_data (32 bit)
//
// Steps: a region request, a zero count or a table run longer than the free
// tail go from decide straight to done; a bump allocation, fit or not, passes
// multiply and add; a table allocation passes multiply, add and the marking
// walk, which writes one page entry a cycle; all of them end in done.
// Pages are used as a prefix of the table, kept as a fill count, so reset
// needs no clearing pass. req is ready only while idle; a waiting response
// word does not block accepting the next request, only its completion.
`timescale 1ns / 1ps

module contiguous_page_allocator_core #(
  parameter int NUM_PAGES  = cpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  cpa_req_if.sink                     req,
  cpa_rsp_if.source                   rsp,
  input  logic                        wr_en,
  input  logic [1:0]                  wr_index,
  input  logic [cpa_pkg::ADDR_W-1:0]  wr_data
);

  localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int MW = (CW > cpa_pkg::COUNT_W) ? CW : cpa_pkg::COUNT_W;
  localparam int AW = cpa_pkg::ADDR_W;

  cpa_pkg::cpa_stat_t stat;
  cpa_pkg::cpa_ctrl_t ctrl;

  // configuration and allocator state
  logic                         table_mode;
  logic [AW-1:0]                table_base;
  logic [AW-1:0]                bump_next;
  logic [AW-1:0]                bump_end;
  logic [CW-1:0]                free_pages;
  logic [CW-1:0]                used_pages;

  // current request
  logic                         cur_req;
  logic [cpa_pkg::COUNT_W-1:0]  cur_count;
  logic [cpa_pkg::OWNER_W-1:0]  cur_owner;

  // working registers
  logic [AW-1:0]                prod_q;
  logic [AW-1:0]                res_addr;
  logic [AW-1:0]                res_lo;
  logic [AW-1:0]                res_hi;
  logic [IW-1:0]                mark_idx;
  logic [cpa_pkg::COUNT_W-1:0]  mark_left;
  logic                         mark_head;

  // response register
  logic                         out_valid;
  logic [AW-1:0]                out_addr;
  logic [AW-1:0]                out_lo;
  logic [AW-1:0]                out_hi;

  // shared unit
  logic [AW-1:0]                alu_mul_a;
  logic [AW-1:0]                alu_add_a;
  logic [AW-1:0]                alu_prod;
  logic [AW:0]                  alu_sum;
  logic                         alu_over;
  logic [AW-1:0]                ram_capped;

  assign alu_mul_a = table_mode ? AW'(used_pages) : AW'(cur_count);
  assign alu_add_a = table_mode ? table_base : bump_next;

  cpa_alu #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_alu (
    .mul_a (alu_mul_a),
    .add_a (alu_add_a),
    .add_b (prod_q),
    .lim   (bump_end),
    .prod  (alu_prod),
    .sum   (alu_sum),
    .over  (alu_over)
  );

  // status to sequencer; a run fits only if it is no longer than the free tail
  always_comb begin
    stat            = '0;
    stat.in_fire    = req.valid && ctrl.in_ready;
    stat.region     = (cur_req == cpa_pkg::REQ_REGION);
    stat.skip       = (cur_count == '0) ||
                      (table_mode && (MW'(cur_count) > MW'(free_pages)));
    stat.table_mode = table_mode;
    stat.mark_last  = (mark_left == cpa_pkg::COUNT_W'(1));
    stat.out_free   = !out_valid || rsp.ready;
  end

  cpa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  cpa_page_mem #(
    .NUM_PAGES (NUM_PAGES),
    .IW        (IW)
  ) u_mem (
    .clk     (clk),
    .we      (ctrl.mark_en),
    .head    (mark_head),
    .addr    (mark_idx),
    .owner   (cur_owner),
    .run_len (cur_count)
  );

  // end of bump region, capped
  assign ram_capped = ({3'b000, wr_data[cpa_pkg::RAM_W-1:0]} > cpa_pkg::RAM_CAP) ?
                      cpa_pkg::RAM_CAP : {3'b000, wr_data[cpa_pkg::RAM_W-1:0]};

  // control state, config writes and bump pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_mode <= 1'b0;
      table_base <= '0;
      bump_next  <= '0;
      bump_end   <= '0;
      free_pages <= CW'(NUM_PAGES);
      used_pages <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (cpa_pkg::cpa_reg_t'(wr_index))
          cpa_pkg::REG_TABLE_MODE: table_mode <= wr_data[0];
          cpa_pkg::REG_BUMP_START: bump_next  <= wr_data;
          cpa_pkg::REG_RAM_SIZE:   bump_end   <= ram_capped;
          cpa_pkg::REG_TABLE_BASE: table_base <= wr_data;
          default: ;
        endcase
      end else if (ctrl.decide && stat.region) begin
        bump_next <= '0;
        bump_end  <= '0;
      end else if (ctrl.add_en && !table_mode && !alu_over) begin
        bump_next <= alu_sum[AW-1:0];
      end

      // one page leaves the free tail per marking cycle
      if (ctrl.mark_en) begin
        free_pages <= free_pages - CW'(1);
        used_pages <= used_pages + CW'(1);
      end

      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (stat.in_fire) begin
      cur_req   <= req.req_type;
      cur_count <= req.page_count;
      cur_owner <= req.owner_id;
    end

    if (ctrl.decide) begin
      res_addr <= '0;
      res_lo   <= stat.region ? bump_next : '0;
      res_hi   <= stat.region ? bump_end  : '0;
    end

    if (ctrl.mul_en) begin
      prod_q <= alu_prod;
    end

    // bump: old pointer unless past the end; table: base plus scaled index
    if (ctrl.add_en) begin
      if (table_mode) begin
        res_addr  <= alu_sum[AW-1:0];
        mark_idx  <= used_pages[IW-1:0];
        mark_left <= cur_count;
        mark_head <= 1'b1;
      end else begin
        res_addr  <= alu_over ? '0 : bump_next;
      end
    end

    if (ctrl.mark_en) begin
      mark_idx  <= mark_idx + IW'(1);
      mark_left <= mark_left - cpa_pkg::COUNT_W'(1);
      mark_head <= 1'b0;
    end

    if (ctrl.emit) begin
      out_addr <= res_addr;
      out_lo   <= res_lo;
      out_hi   <= res_hi;
    end
  end

  assign req.ready     = ctrl.in_ready;
  assign rsp.valid     = out_valid;
  assign rsp.phys_addr = out_addr;
  assign rsp.region_lo = out_lo;
  assign rsp.region_hi = out_hi;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for contiguous_page_allocator_core: random and directed
// request words are checked against a built-in model of the bump and first-fit allocators.
// Depends on cpa_pkg, cpa_req_if / cpa_rsp_if and the core itself.
`timescale 1ns / 1ps

module testbench;

  localparam int ADDR_W     = cpa_pkg::ADDR_W;
  localparam int COUNT_W    = cpa_pkg::COUNT_W;
  localparam int OWNER_W    = cpa_pkg::OWNER_W;
  localparam int RAM_W      = cpa_pkg::RAM_W;
  localparam int PAGES      = cpa_pkg::NUM_PAGES_DEF;
  localparam int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF;
  localparam int SPAN_W     = ADDR_W + 1;
  localparam int LONG_HOLD  = 400;

  typedef struct packed {
    logic               req_type;
    logic [COUNT_W-1:0] page_count;
    logic [OWNER_W-1:0] owner_id;
    bit                 drain_first;  // hold this word until all responses are back
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr;
    logic [ADDR_W-1:0] region_lo;
    logic [ADDR_W-1:0] region_hi;
  } page_grant_t;

  logic              clk;
  logic              rst;
  logic              wr_en;
  cpa_pkg::cpa_reg_t wr_index;
  logic [ADDR_W-1:0] wr_data;

  cpa_req_if req_if ();
  cpa_rsp_if rsp_if ();

  contiguous_page_allocator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Allocator model state
  logic              mode_table;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] bump_next;
  logic [ADDR_W-1:0] bump_end;
  bit                page_taken [PAGES];
  int                pages_free;

  page_req_t   request_queue [$];
  page_grant_t expected_grants [$];

  int n_queued, n_sent, n_checked, n_err;
  int n_granted, n_denied, n_region;

  // Expected response for one accepted request; updates the model state
  function automatic page_grant_t grant_for(page_req_t r);
    page_grant_t     g;
    logic [SPAN_W-1:0] span_end;
    int              run, first, i, j;
    bit              hit;
    g   = '0;
    hit = 1'b0;
    if (r.req_type == cpa_pkg::REQ_REGION) begin
      g.region_lo = bump_next;
      g.region_hi = bump_end;
      bump_next   = '0;
      bump_end    = '0;
      n_region++;
    end else begin
      if (r.page_count != 0 && !mode_table) begin
        // bump: compare without wrap-around
        span_end = {1'b0, bump_next} + SPAN_W'(r.page_count) * SPAN_W'(PAGE_BYTES);
        if (span_end <= {1'b0, bump_end}) begin
          g.phys_addr = bump_next;
          bump_next   = span_end[ADDR_W-1:0];
          hit         = 1'b1;
        end
      end else if (r.page_count != 0 && pages_free != 0) begin
        // table: first run of free pages long enough
        run   = 0;
        first = 0;
        i     = 0;
        while (i < PAGES && !hit) begin
          if (page_taken[i]) begin
            run   = 0;
            first = i + 1;
          end else begin
            run++;
          end
          if (run == int'(r.page_count)) begin
            for (j = first; j < first + run; j++) page_taken[j] = 1'b1;
            pages_free -= run;
            g.phys_addr = base_addr + ADDR_W'(first * PAGE_BYTES);
            hit         = 1'b1;
          end
          i++;
        end
      end
      if (hit) n_granted++;
      else n_denied++;
    end
    return g;
  endfunction

  // Per-word wait, drawn at random, with a no-wait stretch every fourth block of 64
  function automatic int idle_draw(int count);
    return ((count / 64) % 4 == 3) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic int field_mismatch(string name, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic void push_req(logic kind, int count, int owner, bit drain);
    page_req_t r;
    r.req_type    = kind;
    r.page_count  = COUNT_W'(count);
    r.owner_id    = OWNER_W'(owner);
    r.drain_first = drain;
    request_queue.push_back(r);
    n_queued++;
  endfunction

  // Mostly small allocations; some zero, oversize and region words as noise
  function automatic void push_random(bit table_phase);
    int sel, count;
    sel = $urandom_range(0, 99);
    if (sel < 4) count = 0;
    else if (sel < 10) count = $urandom_range(100, 511);
    else if (table_phase) count = $urandom_range(1, 4);
    else count = $urandom_range(1, 32);
    if (sel == 99)
      push_req(cpa_pkg::REQ_REGION, $urandom_range(0, 511), $urandom,
               $urandom_range(0, 49) == 0);
    else
      push_req(cpa_pkg::REQ_ALLOC, count, $urandom, $urandom_range(0, 49) == 0);
  endfunction

  task automatic write_reg(cpa_pkg::cpa_reg_t idx, logic [ADDR_W-1:0] data);
    logic [RAM_W-1:0] ram;
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    ram = data[RAM_W-1:0];
    case (idx)
      cpa_pkg::REG_TABLE_MODE: mode_table = data[0];
      cpa_pkg::REG_BUMP_START: bump_next = data;
      cpa_pkg::REG_RAM_SIZE:
        bump_end = (ADDR_W'(ram) > cpa_pkg::RAM_CAP) ? cpa_pkg::RAM_CAP : ADDR_W'(ram);
      cpa_pkg::REG_TABLE_BASE: base_addr = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [ADDR_W-1:0] mode_word, logic [ADDR_W-1:0] start,
                            logic [ADDR_W-1:0] ram, logic [ADDR_W-1:0] base);
    write_reg(cpa_pkg::REG_TABLE_MODE, mode_word);
    write_reg(cpa_pkg::REG_BUMP_START, start);
    write_reg(cpa_pkg::REG_RAM_SIZE, ram);
    write_reg(cpa_pkg::REG_TABLE_BASE, base);
  endtask

  // Wait until every queued request has its response, then a short pause
  task automatic settle(int pause);
    while (n_checked < n_queued) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Request driver
  page_req_t offered;
  int        send_gap;

  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        expected_grants.push_back(grant_for(offered));
        n_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_queue.size() > 0 &&
                     !(request_queue[0].drain_first && expected_grants.size() > 0)) begin
          offered = request_queue.pop_front();
          req_if.req_type   <= offered.req_type;
          req_if.page_count <= offered.page_count;
          req_if.owner_id   <= offered.owner_id;
          next_valid = 1'b1;
          send_gap   = idle_draw(n_sent);
        end
      end
      req_if.valid <= next_valid;
    end
  end

  // Response monitor and receiver stalls
  int take_wait;
  int hold_left;

  always @(posedge clk) begin
    page_grant_t want;
    logic        next_ready;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      take_wait = 0;
      hold_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected response word, expected none, got %h %h %h",
                   $time, rsp_if.phys_addr, rsp_if.region_lo, rsp_if.region_hi);
          n_err++;
        end else begin
          want = expected_grants.pop_front();
          n_err += field_mismatch("phys_addr", want.phys_addr, rsp_if.phys_addr);
          n_err += field_mismatch("region_lo", want.region_lo, rsp_if.region_lo);
          n_err += field_mismatch("region_hi", want.region_hi, rsp_if.region_hi);
        end
        n_checked++;
        take_wait = idle_draw(n_checked);
        // long back-pressure so the core stalls its request side
        if (n_checked == 300 || n_checked == 800) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (take_wait > 0) begin
        take_wait--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      rsp_if.ready <= next_ready;
    end
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    bit                table_plan [8];
    logic [ADDR_W-1:0] start, ram, base;
    int                ph, k;
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = cpa_pkg::REG_TABLE_MODE;
    wr_data           = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = cpa_pkg::REQ_ALLOC;
    req_if.page_count = '0;
    req_if.owner_id   = '0;
    rsp_if.ready      = 1'b0;
    mode_table        = 1'b0;
    base_addr         = '0;
    bump_next         = '0;
    bump_end          = '0;
    pages_free        = PAGES;
    table_plan        = '{0, 1, 0, 1, 0, 0, 1, 0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty bump region: everything fails, region reads zero
    set_config(32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 0, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 0, 16'hFFFF, 1'b0);
    push_req(cpa_pkg::REQ_REGION, 0, 0, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 256, 16'h8001, 1'b0);
    settle(8);

    // bump with RAM size above the cap, then region read clears it
    set_config(32'h0, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'h0001, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 511, 16'hFFFF, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 0, 16'h5A5A, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 256, 16'hA5A5, 1'b0);
    push_req(cpa_pkg::REQ_REGION, 511, 16'hFFFF, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'h0002, 1'b0);
    settle(8);

    // bump right at the top of the cap: overflow by one page, then exact fit
    set_config(32'h0, cpa_pkg::RAM_CAP - PAGE_BYTES, cpa_pkg::RAM_CAP, 32'h0);
    push_req(cpa_pkg::REQ_ALLOC, 2, 16'h0100, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'h0200, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'h0400, 1'b0);
    settle(8);

    // start above the region end never fits
    set_config(32'h0, 32'hFFFF_FFFF, 32'h1FFF_FFFF, 32'h0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'h0800, 1'b0);
    push_req(cpa_pkg::REQ_REGION, 3, 16'h1000, 1'b0);
    settle(8);

    // table mode with a base that wraps past 2^32
    set_config(32'h8000_0001, 32'h0010_0000, 32'h0100_0000, 32'hFFFF_E000);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'h1234, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 2, 16'h2000, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 3, 16'h4000, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 0, 16'h0000, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 256, 16'h7FFF, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 257, 16'hC000, 1'b0);
    push_req(cpa_pkg::REQ_REGION, 9, 16'h0F0F, 1'b0);
    push_req(cpa_pkg::REQ_ALLOC, 1, 16'hFFFF, 1'b0);
    settle(8);

    // random phases, with bump or table settings as table_plan picks for each
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 4) begin
        start = $urandom;
        ram   = $urandom;
      end else begin
        start = ADDR_W'($urandom_range(0, 4096)) * PAGE_BYTES;
        if ($urandom_range(0, 3) == 0) start = start + ADDR_W'($urandom_range(1, 4095));
        ram = start + ADDR_W'($urandom_range(64, 4096)) * PAGE_BYTES;
      end
      base = (ph == 1) ? $urandom : (ph == 3) ? 32'h0 : 32'hFFFF_FFFF;
      set_config(($urandom & 32'hFFFF_FFFE) | ADDR_W'(table_plan[ph]),
                 start, ram, base);
      for (k = 0; k < 143; k++) push_random(table_plan[ph]);
      if (!table_plan[ph])
        push_req(cpa_pkg::REQ_REGION, $urandom_range(0, 511), $urandom, 1'b0);
      settle(8);
    end

    settle(PAGES + 10);
    $display("Sent %0d requests: %0d granted, %0d refused, %0d region reads; %0d of %0d %s",
             n_sent, n_granted, n_denied, n_region, PAGES - pages_free, PAGES,
             "pages in use.");
    $display("Checked %0d response words, %0d field mismatches.", n_checked, n_err);
    if (n_err == 0 && expected_grants.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
